@@ rtl/core/prts_pkg.sv @@
// Shared types and codes for the periodic and repeated timer bank.
package prts_pkg;

    localparam int ID_W        = 16;
    localparam int REP_W       = 16;
    localparam int IN_PERIOD_W = 24;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] MODE_ADD_PER = 2'd0;
    localparam logic [1:0] MODE_ADD_REP = 2'd1;
    localparam logic [1:0] MODE_CANCEL  = 2'd2;
    localparam logic [1:0] MODE_TICK    = 2'd3;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;

    typedef struct packed {
        logic [1:0]       mode;
        logic [REP_W-1:0] reps;
        logic [ID_W-1:0]  cancel_id;
    } t_cmd;

    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] id;
        logic            last;
    } t_res;

endpackage

@@ rtl/core/periodic_repeat_timer_scheduler.sv @@
// Top level of the periodic and repeated timer bank.
// A command beat (add periodic, add repeated, cancel, tick) is taken when start is high and
// busy is low; a two-entry queue holds commands while the scan engine works, and busy rises
// only when that queue is full. The engine walks the slot memory one slot per cycle through
// its single read port; a tick visits every slot, while an add or a cancel stops at the slot
// that it finds, and one that finds none visits every slot.
// Each result beat is shown for exactly one cycle with o_valid high and cannot be held off.
// An add or a cancel gives one beat with o_last set; a tick gives one fired beat per
// expiring slot in ascending slot order, at most 16, the final one with o_last set, and no
// beat at all when nothing expires. Timers fire on the first tick after they are added.
module periodic_repeat_timer_scheduler #(
    parameter int NUM_SLOTS   = 16,
    parameter int PERIOD_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_mode,
    input  logic [prts_pkg::IN_PERIOD_W-1:0]  i_period_ms,
    input  logic [prts_pkg::REP_W-1:0]        i_repeat_count,
    input  logic [prts_pkg::ID_W-1:0]         i_cancel_id,
    output logic                              o_valid,
    output logic [2:0]                        o_kind,
    output logic [prts_pkg::ID_W-1:0]         o_result_id,
    output logic                              o_last
);
    import prts_pkg::*;

    logic                   q_valid;
    t_cmd                   q_cmd;
    logic [PERIOD_BITS-1:0] q_per;
    logic                   q_pop;
    t_res                   res;

    prts_front #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_period_ms    (i_period_ms),
        .i_repeat_count (i_repeat_count),
        .i_cancel_id    (i_cancel_id),
        .o_q_valid      (q_valid),
        .o_q_cmd        (q_cmd),
        .o_q_per        (q_per),
        .i_q_pop        (q_pop)
    );

    prts_back #(
        .NUM_SLOTS   (NUM_SLOTS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .i_q_per     (q_per),
        .o_q_pop     (q_pop),
        .o_res_valid (o_valid),
        .o_res       (res)
    );

    assign o_kind      = res.kind;
    assign o_result_id = res.id;
    assign o_last      = res.last;

endmodule

@@ rtl/core/prts_front.sv @@
// Command intake: accept, classify and clamp commands, queue them for the scan engine.
module prts_front #(
    parameter int PERIOD_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_mode,
    input  logic [prts_pkg::IN_PERIOD_W-1:0]  i_period_ms,
    input  logic [prts_pkg::REP_W-1:0]        i_repeat_count,
    input  logic [prts_pkg::ID_W-1:0]         i_cancel_id,
    output logic                              o_q_valid,
    output prts_pkg::t_cmd                    o_q_cmd,
    output logic [PERIOD_BITS-1:0]            o_q_per,
    input  logic                              i_q_pop
);
    import prts_pkg::*;

    localparam logic [63:0] PER_LIMIT = (64'd1 << PERIOD_BITS) - 64'd1;

    logic [63:0]            per_ext;
    logic [63:0]            per_sat;
    logic [PERIOD_BITS-1:0] per_c;
    t_cmd                   cmd_c;
    logic                   push;

    t_cmd                   r_q_cmd [2];
    logic [PERIOD_BITS-1:0] r_q_per [2];
    logic                   r_wp;
    logic                   r_rp;
    logic [1:0]             r_cnt;
    logic                   n_wp;
    logic                   n_rp;
    logic [1:0]             n_cnt;

    always_comb begin
        per_ext = {{(64 - IN_PERIOD_W){1'b0}}, i_period_ms};
        per_sat = (per_ext > PER_LIMIT) ? PER_LIMIT : per_ext;
        per_c   = per_sat[PERIOD_BITS-1:0];
        cmd_c.mode      = i_mode;
        cmd_c.reps      = (i_mode == MODE_ADD_REP) ? i_repeat_count : '0;
        cmd_c.cancel_id = (i_mode == MODE_CANCEL) ? i_cancel_id : '0;
    end

    assign busy = (r_cnt == 2'd2);
    assign push = start && !busy;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = ~r_wp;
        end
        if (i_q_pop) begin
            n_rp = ~r_rp;
        end
        unique case ({push, i_q_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_cmd[r_wp] <= cmd_c;
            r_q_per[r_wp] <= (i_mode == MODE_ADD_PER || i_mode == MODE_ADD_REP) ? per_c : '0;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q_cmd[r_rp];
    assign o_q_per   = r_q_per[r_rp];

endmodule

@@ rtl/core/prts_back.sv @@
// Slot scan engine: timer slot memory, add, cancel and tick processing, result beats.
module prts_back #(
    parameter int NUM_SLOTS   = 16,
    parameter int PERIOD_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  prts_pkg::t_cmd         i_q_cmd,
    input  logic [PERIOD_BITS-1:0] i_q_per,
    output logic                   o_q_pop,
    output logic                   o_res_valid,
    output prts_pkg::t_res         o_res
);
    import prts_pkg::*;

    localparam int           SW        = $clog2(NUM_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    typedef struct packed {
        logic                   periodic;
        logic [ID_W-1:0]        ident;
        logic [PERIOD_BITS-1:0] period;
        logic [PERIOD_BITS-1:0] countdown;
        logic [REP_W-1:0]       reps;
    } t_entry;

    t_entry mem [NUM_SLOTS];

    logic [1:0]             r_state,      n_state;
    logic [SW-1:0]          r_idx,        n_idx;
    logic                   r_p_valid,    n_p_valid;
    logic [SW-1:0]          r_p_idx,      n_p_idx;
    logic [NUM_SLOTS-1:0]   r_active,     n_active;
    t_cmd                   r_cmd,        n_cmd;
    logic [PERIOD_BITS-1:0] r_per,        n_per;
    logic [ID_W-1:0]        r_next_id,    n_next_id;
    logic [FIRE_CNT_W-1:0]  r_fired,      n_fired;
    logic                   r_pend_valid, n_pend_valid;
    logic [ID_W-1:0]        r_pend_id,    n_pend_id;
    logic                   r_out_valid,  n_out_valid;
    t_res                   r_out,        n_out;
    t_entry                 r_rd;

    logic                   mem_we;
    t_entry                 mem_wdata;
    logic                   cur_active;
    logic [PERIOD_BITS-1:0] cd_dec;
    logic                   is_add;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_p_valid    = r_p_valid;
        n_p_idx      = r_p_idx;
        n_active     = r_active;
        n_cmd        = r_cmd;
        n_per        = r_per;
        n_next_id    = r_next_id;
        n_fired      = r_fired;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        o_q_pop      = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = r_rd;
        cur_active   = r_active[r_p_idx];
        cd_dec       = (r_rd.countdown != '0) ? (r_rd.countdown - 1'b1) : '0;
        is_add       = (r_cmd.mode == MODE_ADD_PER) || (r_cmd.mode == MODE_ADD_REP);

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop      = 1'b1;
                    n_cmd        = i_q_cmd;
                    n_per        = i_q_per;
                    n_idx        = '0;
                    n_fired      = '0;
                    n_pend_valid = 1'b0;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_p_valid = 1'b1;
                n_p_idx   = r_idx;
                n_idx     = r_idx + 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_p_valid = 1'b0;
                n_state   = ST_FLUSH;
            end
            ST_FLUSH: begin
                n_state = ST_IDLE;
                if (is_add) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_FULL, id: '0, last: 1'b1};
                end else if (r_cmd.mode == MODE_CANCEL) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_UNKNOWN, id: r_cmd.cancel_id, last: 1'b1};
                end else if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_FIRED, id: r_pend_id, last: 1'b1};
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // evaluate the slot whose entry was read last cycle
        if (r_p_valid) begin
            unique case (r_cmd.mode)
                MODE_ADD_PER, MODE_ADD_REP: begin
                    if (!cur_active) begin
                        n_active[r_p_idx]   = 1'b1;
                        mem_we              = 1'b1;
                        mem_wdata.periodic  = (r_cmd.mode == MODE_ADD_PER);
                        mem_wdata.ident     = r_next_id;
                        mem_wdata.period    = r_per;
                        mem_wdata.countdown = '0;
                        mem_wdata.reps      = (r_cmd.mode == MODE_ADD_PER) ? '0 : r_cmd.reps;
                        n_out_valid         = 1'b1;
                        n_out       = '{kind: KIND_ADDED, id: r_next_id, last: 1'b1};
                        n_next_id   = r_next_id + 1'b1;
                        n_p_valid   = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end
                MODE_CANCEL: begin
                    if (cur_active && r_rd.ident == r_cmd.cancel_id) begin
                        n_active[r_p_idx] = 1'b0;
                        n_out_valid       = 1'b1;
                        n_out     = '{kind: KIND_CANCELLED, id: r_cmd.cancel_id, last: 1'b1};
                        n_p_valid = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
                MODE_TICK: begin
                    if (cur_active) begin
                        mem_we              = 1'b1;
                        mem_wdata.countdown = cd_dec;
                        if (cd_dec == '0 && r_fired != FIRE_CNT_W'(MAX_RESULTS)) begin
                            // hold this firing until the next one shows whether it ends the tick
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out = '{kind: KIND_FIRED, id: r_pend_id, last: 1'b0};
                            end
                            n_pend_valid = 1'b1;
                            n_pend_id    = r_rd.ident;
                            n_fired      = r_fired + 1'b1;
                            if (r_rd.periodic) begin
                                mem_wdata.countdown = r_rd.period;
                            end else if (r_rd.reps != '0) begin
                                mem_wdata.reps      = r_rd.reps - 1'b1;
                                mem_wdata.countdown = r_rd.period;
                            end else begin
                                n_active[r_p_idx] = 1'b0;
                            end
                        end
                    end
                end
                default: n_state = n_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_p_valid    <= 1'b0;
            r_active     <= '0;
            r_next_id    <= '0;
            r_fired      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_p_valid    <= n_p_valid;
            r_active     <= n_active;
            r_next_id    <= n_next_id;
            r_fired      <= n_fired;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_idx   <= n_p_idx;
        r_cmd     <= n_cmd;
        r_per     <= n_per;
        r_pend_id <= n_pend_id;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_p_idx] <= mem_wdata;
        end
        r_rd <= mem[r_idx];
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the periodic and repeated timer bank.
module testbench;
    import prts_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int PERIOD_BITS = 24;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};

    typedef struct packed {
        logic [1:0]             mode;
        logic [IN_PERIOD_W-1:0] period;
        logic [REP_W-1:0]       reps;
        logic [ID_W-1:0]        cancel_id;
    } t_timer_cmd;

    typedef struct packed {
        t_timer_cmd cmd;
        logic       typed;
        t_res       want;
    } t_plan_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             i_mode = '0;
    logic [IN_PERIOD_W-1:0] i_period_ms = '0;
    logic [REP_W-1:0]       i_repeat_count = '0;
    logic [ID_W-1:0]        i_cancel_id = '0;
    logic                   o_valid;
    logic [2:0]             o_kind;
    logic [ID_W-1:0]        o_result_id;
    logic                   o_last;

    logic                   slot_on     [NUM_SLOTS];
    logic                   slot_per    [NUM_SLOTS];
    logic [ID_W-1:0]        slot_tag    [NUM_SLOTS];
    logic [PERIOD_BITS-1:0] slot_reload [NUM_SLOTS];
    logic [PERIOD_BITS-1:0] slot_count  [NUM_SLOTS];
    logic [REP_W-1:0]       slot_reps   [NUM_SLOTS];
    logic [ID_W-1:0]        id_next;

    t_res       step_beats [MAX_RESULTS];
    int         step_count;
    t_res       pending_beats [$];
    t_res       head;
    t_plan_row  plan [$];
    int         fail_count = 0;
    int         cycle_count = 0;

    periodic_repeat_timer_scheduler #(
        .NUM_SLOTS   (NUM_SLOTS),
        .PERIOD_BITS (PERIOD_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_period_ms    (i_period_ms),
        .i_repeat_count (i_repeat_count),
        .i_cancel_id    (i_cancel_id),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_result_id    (o_result_id),
        .o_last         (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_res mk_beat(input logic [2:0] kind, input logic [ID_W-1:0] id,
                                     input logic last);
        return {kind, id, last};
    endfunction

    function automatic t_timer_cmd mk_cmd(input logic [1:0] mode,
                                          input logic [IN_PERIOD_W-1:0] period,
                                          input logic [REP_W-1:0] reps,
                                          input logic [ID_W-1:0] cid);
        return {mode, period, reps, cid};
    endfunction

    function automatic t_plan_row row(input t_timer_cmd cmd, input logic typed,
                                      input logic [2:0] kind, input logic [ID_W-1:0] id);
        return {cmd, typed, mk_beat(kind, id, 1'b1)};
    endfunction

    task automatic timer_bank_step(input t_timer_cmd c);
        int  s;
        bit  hit;
        step_count = 0;
        hit = 1'b0;
        case (c.mode)
            MODE_ADD_PER, MODE_ADD_REP: begin
                for (s = 0; s < NUM_SLOTS && !hit; s++) begin
                    if (!slot_on[s]) begin
                        hit = 1'b1;
                        slot_on[s]     = 1'b1;
                        slot_per[s]    = (c.mode == MODE_ADD_PER);
                        slot_tag[s]    = id_next;
                        slot_reload[s] = (c.period > PERIOD_MAX) ? PERIOD_MAX : c.period;
                        slot_count[s]  = '0;
                        slot_reps[s]   = (c.mode == MODE_ADD_PER) ? '0 : c.reps;
                        step_beats[0]  = mk_beat(KIND_ADDED, id_next, 1'b1);
                        id_next        = id_next + 1'b1;
                    end
                end
                if (!hit)
                    step_beats[0] = mk_beat(KIND_FULL, '0, 1'b1);
                step_count = 1;
            end
            MODE_CANCEL: begin
                for (s = 0; s < NUM_SLOTS && !hit; s++) begin
                    if (slot_on[s] && slot_tag[s] == c.cancel_id) begin
                        hit = 1'b1;
                        slot_on[s] = 1'b0;
                    end
                end
                step_beats[0] = mk_beat(hit ? KIND_CANCELLED : KIND_UNKNOWN, c.cancel_id, 1'b1);
                step_count = 1;
            end
            default: begin
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (slot_on[s]) begin
                        if (slot_count[s] != 0)
                            slot_count[s] = slot_count[s] - 1'b1;
                        if (slot_count[s] == 0 && step_count < MAX_RESULTS) begin
                            step_beats[step_count] = mk_beat(KIND_FIRED, slot_tag[s], 1'b0);
                            step_count++;
                            if (slot_per[s]) begin
                                slot_count[s] = slot_reload[s];
                            end else if (slot_reps[s] > 0) begin
                                slot_reps[s]  = slot_reps[s] - 1'b1;
                                slot_count[s] = slot_reload[s];
                            end else begin
                                slot_on[s] = 1'b0;
                            end
                        end
                    end
                end
                if (step_count > 0)
                    step_beats[step_count-1].last = 1'b1;
            end
        endcase
    endtask

    task automatic issue(input t_timer_cmd c, input logic typed, input t_res want,
                         input int gap);
        int i;
        start          <= 1'b1;
        i_mode         <= c.mode;
        i_period_ms    <= c.period;
        i_repeat_count <= c.reps;
        i_cancel_id    <= c.cancel_id;
        do @(posedge i_clk); while (busy);
        timer_bank_step(c);
        if (typed)
            pending_beats.push_back(want);
        else
            for (i = 0; i < step_count; i++)
                pending_beats.push_back(step_beats[i]);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_timer_cmd random_cmd();
        t_timer_cmd     c;
        logic [ID_W-1:0] live [$];
        int             r;
        int             s;
        c.period    = IN_PERIOD_W'($urandom);
        c.reps      = REP_W'($urandom);
        c.cancel_id = ID_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30)
            c.mode = MODE_TICK;
        else if (r < 50)
            c.mode = MODE_ADD_PER;
        else if (r < 68)
            c.mode = MODE_ADD_REP;
        else
            c.mode = MODE_CANCEL;
        if (c.mode != MODE_TICK) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                c.period = IN_PERIOD_W'($urandom_range(0, 4));
            else if (r < 9)
                c.period = IN_PERIOD_W'($urandom_range(0, 40));
            if ($urandom_range(0, 9) != 0)
                c.reps = REP_W'($urandom_range(0, 3));
        end
        if (c.mode == MODE_CANCEL && $urandom_range(0, 9) < 8) begin
            for (s = 0; s < NUM_SLOTS; s++)
                if (slot_on[s])
                    live.push_back(slot_tag[s]);
            if (live.size() > 0)
                c.cancel_id = live[$urandom_range(0, live.size() - 1)];
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: kind %0d id %0d last %0d",
                       o_kind, o_result_id, o_last);
                fail_count++;
            end else begin
                head = pending_beats.pop_front();
                if (o_kind !== head.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", head.kind, o_kind);
                    fail_count++;
                end
                if (o_result_id !== head.id) begin
                    $error("result_id mismatch: expected %0d, actual %0d",
                           head.id, o_result_id);
                    fail_count++;
                end
                if (o_last !== head.last) begin
                    $error("last mismatch: expected %0d, actual %0d", head.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int               i;
        int               s;
        bit               idle_on;
        logic [ID_W-1:0]  kept;
        t_res             none;

        none = '0;
        for (s = 0; s < NUM_SLOTS; s++) begin
            slot_on[s]  = 1'b0;
            slot_per[s] = 1'b0;
        end
        id_next = '0;

        plan.push_back(row(mk_cmd(MODE_CANCEL, '0, '0, '0), 1'b1, KIND_UNKNOWN, 16'd0));
        plan.push_back(row(mk_cmd(MODE_TICK, '1, '1, '1), 1'b0, KIND_FIRED, '0));
        plan.push_back(row(mk_cmd(MODE_ADD_PER, '0, '1, '1), 1'b1, KIND_ADDED, 16'd0));
        plan.push_back(row(mk_cmd(MODE_ADD_REP, '0, '0, '0), 1'b1, KIND_ADDED, 16'd1));
        plan.push_back(row(mk_cmd(MODE_ADD_REP, 24'd1, 16'd2, '0), 1'b1, KIND_ADDED, 16'd2));
        plan.push_back(row(mk_cmd(MODE_ADD_PER, '1, '0, '0), 1'b1, KIND_ADDED, 16'd3));
        plan.push_back(row(mk_cmd(MODE_ADD_REP, '1, '1, '0), 1'b1, KIND_ADDED, 16'd4));
        plan.push_back(row(mk_cmd(MODE_TICK, '0, '0, '0), 1'b0, KIND_FIRED, '0));
        plan.push_back(row(mk_cmd(MODE_TICK, '0, '0, '0), 1'b0, KIND_FIRED, '0));
        plan.push_back(row(mk_cmd(MODE_CANCEL, '0, '0, 16'd3), 1'b1, KIND_CANCELLED, 16'd3));
        for (i = 0; i < 13; i++)
            plan.push_back(row(mk_cmd(i[0] ? MODE_ADD_PER : MODE_ADD_REP,
                                      IN_PERIOD_W'(i), '0, '0),
                               1'b1, KIND_ADDED, 16'(5 + i)));
        plan.push_back(row(mk_cmd(MODE_ADD_REP, '1, '1, '1), 1'b1, KIND_FULL, 16'd0));
        plan.push_back(row(mk_cmd(MODE_TICK, '0, '0, '0), 1'b0, KIND_FIRED, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i])
            issue(plan[i].cmd, plan[i].typed, plan[i].want, $urandom_range(0, 13));

        idle_on = 1'b1;
        for (i = 0; i < 420; i++) begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            issue(random_cmd(), 1'b0, none, idle_on ? $urandom_range(0, 13) : 0);
        end

        // Drain the bank, add two periodic timers and tick twice, then cancel the first one's id three times.
        for (s = 0; s < NUM_SLOTS; s++)
            if (slot_on[s])
                issue(mk_cmd(MODE_CANCEL, IN_PERIOD_W'($urandom), REP_W'($urandom),
                             slot_tag[s]), 1'b0, none, 0);
        kept = id_next;
        issue(mk_cmd(MODE_ADD_PER, '1, REP_W'($urandom), ID_W'($urandom)), 1'b0, none, 0);
        issue(mk_cmd(MODE_ADD_PER, 24'd1, REP_W'($urandom), ID_W'($urandom)), 1'b0, none, 0);
        issue(mk_cmd(MODE_TICK, IN_PERIOD_W'($urandom), REP_W'($urandom), ID_W'($urandom)),
              1'b0, none, 0);
        issue(mk_cmd(MODE_TICK, IN_PERIOD_W'($urandom), REP_W'($urandom), ID_W'($urandom)),
              1'b0, none, 0);
        repeat (3)
            issue(mk_cmd(MODE_CANCEL, IN_PERIOD_W'($urandom), REP_W'($urandom), kept),
                  1'b0, none, 0);

        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (3 * (NUM_SLOTS + 3) + 16) @(posedge i_clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
